// ----- rtl/core/spd_pkg.sv -----
package spd_pkg;

   // Store capacity in points.
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int COORD_W = 16;
   localparam int MAG_W   = 16;
   localparam int PROD_W  = 2 * MAG_W;
   localparam int DIST_W  = 34;
   localparam int PT_W    = 3 * COORD_W;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC  = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      last_out;
      logic                      overflowed;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] sq_dist;
   } dist_rsp_type;

   typedef struct packed {
      logic             start;
      logic             first;
      logic             descending;
      logic [CNT_W-1:0] count;
   } sel_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] index;
   } sel_rsp_type;

endpackage

// ----- rtl/core/spd_ram.sv -----
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/spd_dist.sv -----
module spd_dist import spd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  req_type                   point,
   input  logic signed [COORD_W-1:0] ref_x,
   input  logic signed [COORD_W-1:0] ref_y,
   input  logic signed [COORD_W-1:0] ref_z,
   output dist_rsp_type              dist_rsp
);

   // Three axes flow through one abs-difference stage, one multiplier and
   // one accumulator; the step counter walks the axes and drains the pipe.
   localparam logic [2:0] STEP_LAST = 3'd4;
   localparam logic [2:0] STEP_ACC0 = 3'd2;

   logic              run_ff, run_in;
   logic [2:0]        step_ff, step_in;
   logic              done_ff, done_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIST_W-1:0] acc_ff, acc_in;

   logic signed [COORD_W-1:0] coord_a;
   logic signed [COORD_W-1:0] coord_r;
   logic signed [COORD_W:0]   diff;
   logic        [COORD_W:0]   neg_diff;

   always_comb begin
      case (step_ff)
         3'd1: begin
            coord_a = point.point_y;
            coord_r = ref_y;
         end
         3'd2: begin
            coord_a = point.point_z;
            coord_r = ref_z;
         end
         default: begin
            coord_a = point.point_x;
            coord_r = ref_x;
         end
      endcase
      diff     = {coord_a[COORD_W-1], coord_a} - {coord_r[COORD_W-1], coord_r};
      neg_diff = (COORD_W+1)'(-diff);
      mag_in   = diff[COORD_W] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
      prod_in  = PROD_W'(mag_ff) * PROD_W'(mag_ff);
      acc_in   = acc_ff;
      if (run_ff && step_ff >= STEP_ACC0) begin
         acc_in = (step_ff == STEP_ACC0) ? DIST_W'(prod_ff)
                                         : acc_ff + DIST_W'(prod_ff);
      end
   end

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign dist_rsp.done    = done_ff;
   assign dist_rsp.sq_dist = acc_ff;

endmodule

// ----- rtl/core/spd_sel.sv -----
module spd_sel import spd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sel_req_type       sel_req,
   input  logic [DIST_W-1:0] rd_dist,
   output logic [ADDR_W-1:0] rd_addr,
   output sel_rsp_type       sel_rsp
);

   // One pass over the stored distances finds the next entry in sorted
   // order: the best entry that still comes after the previous winner,
   // where equal distances are ordered by index.
   logic              issue_ff, issue_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic              done_ff, done_in;
   logic              desc_ff, desc_in;
   logic              best_valid_ff, best_valid_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [DIST_W-1:0] prev_dist_ff, prev_dist_in;
   logic [ADDR_W-1:0] prev_idx_ff, prev_idx_in;

   logic [CNT_W-1:0] cnt_next;
   logic             eligible;
   logic             better;

   assign cnt_next = cnt_ff + CNT_W'(1);

   always_comb begin
      eligible = !prev_valid_ff
              || (desc_ff ? (rd_dist < prev_dist_ff) : (rd_dist > prev_dist_ff))
              || ((rd_dist == prev_dist_ff) && (rd_idx_ff > prev_idx_ff));
      better   = !best_valid_ff
              || (desc_ff ? (rd_dist > best_dist_ff) : (rd_dist < best_dist_ff));
   end

   always_comb begin
      issue_in      = issue_ff;
      cnt_in        = cnt_ff;
      desc_in       = desc_ff;
      best_valid_in = best_valid_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      prev_valid_in = prev_valid_ff;
      prev_dist_in  = prev_dist_ff;
      prev_idx_in   = prev_idx_ff;
      rd_valid_in   = issue_ff;
      rd_last_in    = issue_ff && (cnt_next == sel_req.count);
      done_in       = rd_valid_ff && rd_last_ff;

      if (issue_ff) begin
         cnt_in = cnt_next;
         if (cnt_next == sel_req.count) begin
            issue_in = 1'b0;
         end
      end

      if (rd_valid_ff && eligible && better) begin
         best_valid_in = 1'b1;
         best_dist_in  = rd_dist;
         best_idx_in   = rd_idx_ff;
      end

      if (done_ff) begin
         prev_valid_in = 1'b1;
         prev_dist_in  = best_dist_ff;
         prev_idx_in   = best_idx_ff;
      end

      if (sel_req.start) begin
         issue_in      = 1'b1;
         cnt_in        = '0;
         desc_in       = sel_req.descending;
         best_valid_in = 1'b0;
         if (sel_req.first) begin
            prev_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= 1'b0;
         cnt_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         done_ff       <= 1'b0;
         desc_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         issue_ff      <= issue_in;
         cnt_ff        <= cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rd_last_ff    <= rd_last_in;
         done_ff       <= done_in;
         desc_ff       <= desc_in;
         best_valid_ff <= best_valid_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= cnt_ff[ADDR_W-1:0];
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      prev_dist_ff <= prev_dist_in;
      prev_idx_ff  <= prev_idx_in;
   end

   assign rd_addr       = cnt_ff[ADDR_W-1:0];
   assign sel_rsp.done  = done_ff;
   assign sel_rsp.index = best_idx_ff;

endmodule

// ----- rtl/core/sort_points_by_distance_top.sv -----
// Distance sort of a 3D point set.
// A point set is loaded one transaction at a time: a request is taken when
// start is high and busy is low, and req_data carries the point in signed
// Q8.8 plus a flag that marks the final point of the set. Each stored point
// keeps its squared distance to the reference point held in the csr_
// registers, computed by one shared multiplier over the three axes.
// Loading a point keeps busy high until its distance is stored; a point
// that arrives with the store full is dropped in the request cycle itself
// and sets the overflow flag for the set.
// After the final point the block emits the whole set, one response
// transaction per stored point, sorted nearest first or farthest first.
// Equal distances keep their load order. Each response needs one pass over
// the distance memory, and no new point is taken until the whole set is
// out. A response is shown for one cycle with rsp_valid high; the
// receiver has no way to stall it. The last response carries last_out,
// and busy drops in that same cycle so the next set can start at once.
// Reset empties the set, clears the overflow flag and the reference point.
// Configuration writes belong in idle periods only.
module sort_points_by_distance_top import spd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CALC  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FETCH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rank_ff, rank_in;
   logic                      dropped_ff, dropped_in;
   logic                      last_ff;
   req_type                   point_ff;
   logic signed [COORD_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic                      desc_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic         dist_start;
   dist_rsp_type dist_rsp;
   sel_req_type  sel_req;
   sel_rsp_type  sel_rsp;
   logic         wr_en;

   logic [ADDR_W-1:0] dist_rd_addr;
   logic [DIST_W-1:0] dist_rd_data;
   logic [PT_W-1:0]   pt_wr_data;
   logic [PT_W-1:0]   pt_rd_data;
   logic              accept;
   logic              full;
   logic              rank_last;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign full       = (count_ff == CNT_W'(MAX_POINTS));
   assign rank_last  = ((rank_ff + CNT_W'(1)) == count_ff);
   assign pt_wr_data = {point_ff.point_z, point_ff.point_y, point_ff.point_x};

   // The reference point and sort direction are plain registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
         desc_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REF_X: ref_x_ff <= csr_wdata;
            CSR_REF_Y: ref_y_ff <= csr_wdata;
            CSR_REF_Z: ref_z_ff <= csr_wdata;
            CSR_DESC:  desc_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Main sequencer: load a point, or drop it when the store is full, then
   // on the final point run one selection pass per response and fetch the winning point.
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rank_in            = rank_ff;
      dropped_in         = dropped_ff;
      dist_start         = 1'b0;
      wr_en              = 1'b0;
      sel_req.start      = 1'b0;
      sel_req.first      = 1'b0;
      sel_req.descending = desc_ff;
      sel_req.count      = count_ff;
      rsp_valid_in       = 1'b0;
      rsp_data_in        = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (full) begin
                  dropped_in = 1'b1;
                  if (req_data.last_point) begin
                     sel_req.start = 1'b1;
                     sel_req.first = 1'b1;
                     rank_in       = '0;
                     state_in      = ST_SCAN;
                  end
               end else begin
                  dist_start = 1'b1;
                  state_in   = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (dist_rsp.done) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (last_ff) begin
                  sel_req.start = 1'b1;
                  sel_req.first = 1'b1;
                  rank_in       = '0;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (sel_rsp.done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.out_x      = pt_rd_data[COORD_W-1:0];
            rsp_data_in.out_y      = pt_rd_data[2*COORD_W-1:COORD_W];
            rsp_data_in.out_z      = pt_rd_data[3*COORD_W-1:2*COORD_W];
            rsp_data_in.last_out   = rank_last;
            rsp_data_in.overflowed = dropped_ff;
            if (rank_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               rank_in       = rank_ff + CNT_W'(1);
               sel_req.start = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rank_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rank_ff      <= rank_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         point_ff <= req_data;
         last_ff  <= req_data.last_point;
      end
      rsp_data_ff <= rsp_data_in;
   end

   spd_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (dist_start),
      .point    (point_ff),
      .ref_x    (ref_x_ff),
      .ref_y    (ref_y_ff),
      .ref_z    (ref_z_ff),
      .dist_rsp (dist_rsp)
   );

   spd_sel u_sel (
      .clock   (clock),
      .reset   (reset),
      .sel_req (sel_req),
      .rd_dist (dist_rd_data),
      .rd_addr (dist_rd_addr),
      .sel_rsp (sel_rsp)
   );

   // Squared distance of each stored point.
   spd_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_POINTS)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (dist_rsp.sq_dist),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   // Packed coordinates of each stored point, read at the selection winner.
   spd_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (pt_wr_data),
      .rd_addr (sel_rsp.index),
      .rd_data (pt_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_dist_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      dist_rsp.done |-> (state_ff == ST_CALC))
      else $error("distance unit finished outside of a point load");

   a_sel_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      sel_rsp.done |-> (state_ff == ST_SCAN))
      else $error("selection pass finished outside of a scan");

   a_last_empties_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_out) |-> ((state_ff == ST_IDLE) && (count_ff == '0)))
      else $error("final response did not leave the set empty and idle");
`endif

endmodule

// ----- dv/spd_sort_checker.sv -----
module spd_sort_checker import spd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    results_owed,
   output int                    results_checked
);

   // Points of the set being loaded, with their squared distances.
   req_type                   held_pts  [MAX_POINTS];
   logic [DIST_W-1:0]         held_dist [MAX_POINTS];
   int                        held_count = 0;
   logic                      dropped    = 1'b0;

   logic signed [COORD_W-1:0] ref_x     = '0;
   logic signed [COORD_W-1:0] ref_y     = '0;
   logic signed [COORD_W-1:0] ref_z     = '0;
   logic                      far_first = 1'b0;

   rsp_type                   sorted_q [$];
   int                        errors  = 0;
   int                        checked = 0;

   always @(posedge clock) begin
      int              dx, dy, dz, j;
      longint unsigned dsum;
      int              order [MAX_POINTS];
      rsp_type         want;
      if (reset) begin
         held_count = 0;
         dropped    = 1'b0;
         ref_x      = '0;
         ref_y      = '0;
         ref_z      = '0;
         far_first  = 1'b0;
         sorted_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REF_X: ref_x     = csr_wdata;
               CSR_REF_Y: ref_y     = csr_wdata;
               CSR_REF_Z: ref_z     = csr_wdata;
               CSR_DESC:  far_first = csr_wdata[0];
               default:   ;
            endcase
         end

         if (start && !busy) begin
            if (held_count < MAX_POINTS) begin
               dx   = int'(req_data.point_x) - int'(ref_x);
               dy   = int'(req_data.point_y) - int'(ref_y);
               dz   = int'(req_data.point_z) - int'(ref_z);
               dsum = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy)
                    + longint'(dz) * longint'(dz);
               held_pts[held_count]  = req_data;
               held_dist[held_count] = dsum[DIST_W-1:0];
               held_count++;
            end else begin
               dropped = 1'b1;
            end

            if (req_data.last_point) begin
               // Insertion sort of indexes; equal distances never move past each other.
               for (int i = 0; i < held_count; i++) begin
                  j = i;
                  while (j > 0 && (far_first ? held_dist[order[j-1]] < held_dist[i]
                                             : held_dist[order[j-1]] > held_dist[i])) begin
                     order[j] = order[j-1];
                     j--;
                  end
                  order[j] = i;
               end
               for (int i = 0; i < held_count; i++) begin
                  want.out_x      = held_pts[order[i]].point_x;
                  want.out_y      = held_pts[order[i]].point_y;
                  want.out_z      = held_pts[order[i]].point_z;
                  want.last_out   = (i == held_count - 1);
                  want.overflowed = dropped;
                  sorted_q.push_back(want);
               end
               held_count = 0;
               dropped    = 1'b0;
            end
         end

         if (rsp_valid) begin
            if (sorted_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: unexpected result x=%h y=%h z=%h last=%b ovf=%b", $realtime,
                           rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                           rsp_data.last_out, rsp_data.overflowed);
            end else begin
               want = sorted_q.pop_front();
               checked++;
               if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                   rsp_data.out_z !== want.out_z || rsp_data.last_out !== want.last_out ||
                   rsp_data.overflowed !== want.overflowed) begin
                  errors++;
                  if (errors <= 10)
                     $display("%t: result %0d expected x=%h y=%h z=%h last=%b ovf=%b, got x=%h y=%h z=%h last=%b ovf=%b",
                              $realtime, checked, want.out_x, want.out_y, want.out_z,
                              want.last_out, want.overflowed, rsp_data.out_x,
                              rsp_data.out_y, rsp_data.out_z, rsp_data.last_out,
                              rsp_data.overflowed);
               end
            end
         end
      end
      mismatch_count  <= errors;
      results_owed    <= sorted_q.size();
      results_checked <= checked;
   end

endmodule

// ----- dv/sort_points_by_distance_top_tb.sv -----
// Stimulus and verdict for the distance sort block. The checker instantiated
// next to the block predicts every sorted run and compares it; this module
// only produces point sets, reference point settings and the final verdict.
module sort_points_by_distance_top_tb;
   import spd_pkg::*;

   localparam int RANDOM_POINTS = 330;
   localparam int DRAIN_CYCLES  = 100;
   // This limit is far above the slowest legal run of the whole test.
   localparam int LIMIT_CYCLES  = 500_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int results_owed;
   int results_checked;

   // The current reference point and order, kept only to aim the stimulus.
   logic [COORD_W-1:0] ref_now [3] = '{'0, '0, '0};
   logic               far_now     = 1'b0;

   int points_sent   = 0;
   int sets_sent     = 0;
   int overflow_sets = 0;
   int far_sets      = 0;

   sort_points_by_distance_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   spd_sort_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed),
      .results_checked (results_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or stops emitting.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results still owed", LIMIT_CYCLES,
               results_owed);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Idle time after a transaction: mostly none or short, now and then long
   // enough to leave the block waiting in the middle of loading a set.
   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 80)
         return $urandom_range(1, 4);
      else if (r < 95)
         return $urandom_range(5, 15);
      else
         return $urandom_range(30, 120);
   endfunction

   // A coordinate: fully random, close to the reference point so that equal
   // distances are common, or one of the corner values.
   function automatic logic [COORD_W-1:0] pick_coord(input int axis);
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return COORD_W'($urandom);
      else if (r < 8)
         return ref_now[axis] + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
      else begin
         case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
         endcase
      end
   endfunction

   // A reference coordinate, biased toward the extremes of the range and toward zero.
   function automatic logic [CSR_DATA_W-1:0] pick_setting();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // One register write, then a quiet wait so that the write enable
   // never has to fall and rise within the same step.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_DESC)
         far_now = data[0];
      else
         ref_now[idx] = data;
   endtask

   task automatic set_reference(input logic [CSR_DATA_W-1:0] x, input logic [CSR_DATA_W-1:0] y,
                                input logic [CSR_DATA_W-1:0] z, input logic desc);
      csr_write(CSR_REF_X, x);
      csr_write(CSR_REF_Y, y);
      csr_write(CSR_REF_Z, z);
      csr_write(CSR_DESC, CSR_DATA_W'(desc));
   endtask

   // Stop sending and wait until every sorted result has come out and the
   // block has finished any point load, so that a register write cannot
   // land on work in flight.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_owed != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   // Offer one point and hold it until the block takes the transaction.
   // start stays high when no gap follows, so back-to-back points never
   // toggle it within one step.
   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic last, input int gap);
      start    <= 1'b1;
      req_data <= '{point_x: x, point_y: y, point_z: z, last_point: last};
      do @(posedge clock); while (busy);
      points_sent++;
      if (last) begin
         sets_sent++;
         if (far_now)
            far_sets++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int   size;
      int   set_no;
      int   random_points;
      bit   steady;
      logic last;
      logic [CSR_IDX_W-1:0] idx;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values: reference at the origin, nearest first. The set holds
      // both corners, the origin, two points at equal distance and one on the z axis.
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, pick_gap(1'b0));
      send_point(16'h8000, 16'h8000, 16'h8000, 1'b0, pick_gap(1'b0));
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h0001, 16'hFFFF, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'hFFFF, 16'h0001, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h0000, 16'h0000, 16'h8000, 1'b1, pick_gap(1'b0));

      // A set of a single point.
      send_point(16'h8000, 16'h7FFF, 16'h0000, 1'b1, pick_gap(1'b0));

      // Reference at a corner and farthest first: the opposite corner gives
      // the largest distance the block can see, the reference itself zero.
      settle();
      set_reference(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
      send_point(16'h8000, 16'h7FFF, 16'h8000, 1'b0, pick_gap(1'b0));
      send_point(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, pick_gap(1'b0));
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h7FFF, 16'h8000, 16'h8000, 1'b1, pick_gap(1'b0));

      // Register changes while a set is loading: the new reference applies
      // only to later points, and the order is the one in force at the sort.
      settle();
      set_reference(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h0064, 16'hFF9C, 16'h0005, 1'b0, pick_gap(1'b0));
      settle();
      csr_write(CSR_REF_X, 16'h0000);
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0, pick_gap(1'b0));
      send_point(16'h8000, 16'h7FFF, 16'h8000, 1'b0, pick_gap(1'b0));
      settle();
      csr_write(CSR_DESC, CSR_DATA_W'(1));
      send_point(16'h0001, 16'h0002, 16'h0003, 1'b1, pick_gap(1'b0));
      settle();

      // Random sets. Most are small; one fills the store exactly and one
      // overruns it, so its final point is dropped but still ends the set.
      set_no        = 0;
      random_points = 0;
      while (random_points < RANDOM_POINTS) begin
         if (set_no == 2)
            size = MAX_POINTS;
         else if (set_no == 7)
            size = MAX_POINTS + $urandom_range(1, 6);
         else if ($urandom_range(0, 9) < 7)
            size = $urandom_range(1, 6);
         else
            size = $urandom_range(7, 16);

         if ($urandom_range(0, 3) == 0) begin
            settle();
            set_reference(pick_setting(), pick_setting(), pick_setting(),
                          logic'($urandom_range(0, 1)));
         end

         steady = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < size; k++) begin
            last = (k == size - 1);
            send_point(pick_coord(0), pick_coord(1), pick_coord(2), last, pick_gap(steady));
            if (!last && $urandom_range(0, 29) == 0) begin
               settle();
               idx = CSR_IDX_W'($urandom_range(0, 3));
               csr_write(idx, (idx == CSR_DESC) ? CSR_DATA_W'($urandom_range(0, 1))
                                                : pick_setting());
            end
         end
         random_points += size;
         if (size > MAX_POINTS)
            overflow_sets++;

         // Now and then let the block drain completely before the next set.
         if ($urandom_range(0, 4) == 0)
            settle();
         set_no++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Loaded %0d points in %0d sets, %0d of them past capacity and %0d sorted farthest first.",
               points_sent, sets_sent, overflow_sets, far_sets);
      $display("Checked %0d sorted results; %0d mismatches, %0d results never seen.",
               results_checked, mismatch_count, results_owed);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
